>>> src/pinv_pkg.sv
package pinv_pkg;

    // Input width and BCD layout: the full value has up to 14 decimal digits,
    // the ID itself is the low 13.
    localparam int ID_W      = 44;
    localparam int ID_DIGITS = 13;
    localparam int BCD_NIB   = ID_DIGITS + 1;
    localparam int BCD_W     = BCD_NIB * 4;

    // Binary-to-BCD conversion: bits shifted in per pipeline stage.
    localparam int DAB_BITS   = 4;
    localparam int DAB_STAGES = ID_W / DAB_BITS;

    // Result field widths
    localparam int STATUS_W = 3;
    localparam int DAY_W    = 7;
    localparam int MONTH_W  = 7;
    localparam int YEAR_W   = 12;
    localparam int YDIG_W   = 10;
    localparam int REGION_W = 7;
    localparam int SERIAL_W = 10;
    localparam int CHECK_W  = 4;
    localparam int SUM_W    = 9;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 3'd0;
    localparam logic [STATUS_W-1:0] ST_COUNT = 3'd1;
    localparam logic [STATUS_W-1:0] ST_YEAR  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_MONTH = 3'd3;
    localparam logic [STATUS_W-1:0] ST_DAY   = 3'd4;
    localparam logic [STATUS_W-1:0] ST_CHECK = 3'd5;

    // Year window and mapping
    localparam logic [YDIG_W-1:0] YEAR_NEW_MAX = 10'd17;
    localparam logic [YDIG_W-1:0] YEAR_OLD_MIN = 10'd927;
    localparam logic [YDIG_W-1:0] YEAR_OLD_MAX = 10'd999;
    localparam logic [YEAR_W-1:0] CENT_OLD     = 12'd1000;
    localparam logic [YEAR_W-1:0] CENT_NEW     = 12'd2000;

    localparam logic [MONTH_W-1:0]  MONTH_MAX  = 7'd12;
    localparam logic [SERIAL_W-1:0] MALE_MAX   = 10'd499;

    // Mod-11 by reciprocal: q = (s * RECIP11) >> RECIP_SH, exact for s < 512
    localparam int              MOD_BASE = 11;
    localparam int              RECIP_SH = 16;
    localparam int              PROD_W   = 22;
    localparam logic [13:0]     RECIP11  = 14'd5958;

    // Check digit weights for digits d0..d11
    localparam logic [2:0] WEIGHTS [ID_DIGITS-1] = '{
        3'd7, 3'd6, 3'd5, 3'd4, 3'd3, 3'd2,
        3'd7, 3'd6, 3'd5, 3'd4, 3'd3, 3'd2
    };

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [DAY_W-1:0]    birth_day;
        logic [MONTH_W-1:0]  birth_month;
        logic [YEAR_W-1:0]   birth_year;
        logic [REGION_W-1:0] region_code;
        logic [SERIAL_W-1:0] serial_code;
        logic                is_female;
        logic [CHECK_W-1:0]  check_digit;
    } t_pinv_res;

    // Month length, February fixed at 28; only its value for a valid month is used.
    function automatic logic [4:0] month_len(input logic [3:0] month);
        logic [4:0] len;
        case (month)
            4'd2:    len = 5'd28;
            4'd4:    len = 5'd30;
            4'd6:    len = 5'd30;
            4'd9:    len = 5'd30;
            4'd11:   len = 5'd30;
            default: len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

>>> src/pinv_if.sv
interface pinv_in_if;
    import pinv_pkg::*;

    logic            valid;
    logic            ready;
    logic [ID_W-1:0] id_number;

    modport source (output valid, output id_number, input ready);
    modport sink   (input valid, input id_number, output ready);
endinterface

interface pinv_out_if;
    import pinv_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [DAY_W-1:0]    birth_day;
    logic [MONTH_W-1:0]  birth_month;
    logic [YEAR_W-1:0]   birth_year;
    logic [REGION_W-1:0] region_code;
    logic [SERIAL_W-1:0] serial_code;
    logic                is_female;
    logic [CHECK_W-1:0]  check_digit;

    modport source (
        output valid, input ready,
        output status, output birth_day, output birth_month, output birth_year,
        output region_code, output serial_code, output is_female, output check_digit
    );
    modport sink (
        input valid, output ready,
        input status, input birth_day, input birth_month, input birth_year,
        input region_code, input serial_code, input is_female, input check_digit
    );
endinterface

>>> src/personal_id_number_validator.sv
// Personal ID number validator (JMBG, mod-11 check digit). Each input beat
// carries a 44-bit binary ID; each produces exactly one output beat with a
// status (0 ok, 1 digit count, 2 year, 3 month, 4 day, 5 check digit; the
// first failing check wins) and the decoded fields, which are always taken
// from the low thirteen decimal digits, also on error. Throughput is one
// beat per clock while the output is not stalled. There are fourteen
// register stages: one capture stage, eleven binary-to-BCD stages (double
// dabble, four bits per stage), one stage for field decode, range checks
// and the weighted digit sum, and one for the mod-11 reduction and final
// status, whose register drives the output. Every stage has its own valid
// bit and moves whenever the stage after it is empty or moving, so a stall
// on the output only backs up as far as needed and bubbles are squeezed
// out. Reset is synchronous, active low, and clears the valid bits only.
// There are no configuration registers and no state carried between IDs.
module personal_id_number_validator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    pinv_in_if.sink     i_in,
    pinv_out_if.source  o_out
);
    import pinv_pkg::*;

    // One double-dabble step per shifted bit, DAB_BITS steps per stage.
    function automatic logic [BCD_W-1:0] dab_bits(input logic [BCD_W-1:0] bcd_in,
                                                   input logic [DAB_BITS-1:0] bits);
        logic [BCD_W-1:0] acc;
        acc = bcd_in;
        for (int b = DAB_BITS - 1; b >= 0; b--) begin
            for (int n = 0; n < BCD_NIB; n++) begin
                if (acc[n*4 +: 4] >= 4'd5) begin
                    acc[n*4 +: 4] = acc[n*4 +: 4] + 4'd3;
                end
            end
            acc = {acc[BCD_W-2:0], bits[b]};
        end
        return acc;
    endfunction

    function automatic logic [6:0] dec2(input logic [3:0] hi, input logic [3:0] lo);
        return 7'(hi) * 7'd10 + 7'(lo);
    endfunction

    function automatic logic [9:0] dec3(input logic [3:0] d2, input logic [3:0] d1,
                                        input logic [3:0] d0);
        return 10'(d2) * 10'd100 + 10'(d1) * 10'd10 + 10'(d0);
    endfunction

    // ---------------------------------------------------------------
    // Stage handshake: stage k loads when it is empty or the next loads.
    // w_en[0] is the capture stage, w_en[DAB_STAGES+1] the decode stage.
    // ---------------------------------------------------------------
    logic [DAB_STAGES+1:0] w_en;
    logic                  w_out_en;

    logic                  r_vld [DAB_STAGES+1];
    logic [BCD_W-1:0]      r_bcd [DAB_STAGES+1];
    logic [ID_W-1:0]       r_bin [DAB_STAGES+1];

    logic                  r_f_vld;
    t_pinv_res             r_f_res;
    logic [SUM_W-1:0]      r_f_sum;

    logic                  r_o_vld;
    t_pinv_res             r_o_res;

    assign w_out_en              = !r_o_vld || o_out.ready;
    assign w_en[DAB_STAGES+1]    = !r_f_vld || w_out_en;

    for (genvar g = 0; g <= DAB_STAGES; g++) begin : g_en
        assign w_en[g] = !r_vld[g] || w_en[g+1];
    end

    assign i_in.ready = w_en[0];

    // Capture stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (w_en[0]) begin
            r_vld[0] <= i_in.valid;
        end
        if (w_en[0]) begin
            r_bcd[0] <= '0;
            r_bin[0] <= i_in.id_number;
        end
    end

    // Binary-to-BCD stages, MSBs first
    for (genvar g = 1; g <= DAB_STAGES; g++) begin : g_dab
        logic [BCD_W-1:0] n_bcd;
        logic [ID_W-1:0]  n_bin;

        assign n_bcd = dab_bits(r_bcd[g-1], r_bin[g-1][ID_W-1 -: DAB_BITS]);
        assign n_bin = {r_bin[g-1][ID_W-DAB_BITS-1:0], {DAB_BITS{1'b0}}};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g] <= 1'b0;
            end else if (w_en[g]) begin
                r_vld[g] <= r_vld[g-1];
            end
            if (w_en[g]) begin
                r_bcd[g] <= n_bcd;
                r_bin[g] <= n_bin;
            end
        end
    end

    // ---------------------------------------------------------------
    // Decode stage: fields, range checks in priority order, digit sum
    // ---------------------------------------------------------------
    logic [3:0]          dig [ID_DIGITS];
    logic [3:0]          dig_top;
    logic [YDIG_W-1:0]   year_dig;
    logic [4:0]          mlen;
    t_pinv_res           n_f_res;
    logic [SUM_W-1:0]    n_f_sum;

    always_comb begin
        // d0 is the most significant of the thirteen ID digits
        for (int k = 0; k < ID_DIGITS; k++) begin
            dig[k] = r_bcd[DAB_STAGES][(ID_DIGITS-1-k)*4 +: 4];
        end
        dig_top = r_bcd[DAB_STAGES][ID_DIGITS*4 +: 4];

        year_dig = dec3(dig[4], dig[5], dig[6]);

        n_f_res.birth_day   = dec2(dig[0], dig[1]);
        n_f_res.birth_month = dec2(dig[2], dig[3]);
        n_f_res.birth_year  = (year_dig >= YEAR_OLD_MIN) ? CENT_OLD + YEAR_W'(year_dig)
                                                        : CENT_NEW + YEAR_W'(year_dig);
        n_f_res.region_code = dec2(dig[7], dig[8]);
        n_f_res.serial_code = dec3(dig[9], dig[10], dig[11]);
        n_f_res.is_female   = n_f_res.serial_code > MALE_MAX;
        n_f_res.check_digit = dig[ID_DIGITS-1];

        mlen = month_len(n_f_res.birth_month[3:0]);

        // 12 or 13 digits: nothing above d0, and d0/d1 not both zero
        if (dig_top != 4'd0 || (dig[0] == 4'd0 && dig[1] == 4'd0)) begin
            n_f_res.status = ST_COUNT;
        end else if (!(year_dig <= YEAR_NEW_MAX ||
                       (year_dig >= YEAR_OLD_MIN && year_dig <= YEAR_OLD_MAX))) begin
            n_f_res.status = ST_YEAR;
        end else if (n_f_res.birth_month == '0 || n_f_res.birth_month > MONTH_MAX) begin
            n_f_res.status = ST_MONTH;
        end else if (n_f_res.birth_day == '0 || n_f_res.birth_day > DAY_W'(mlen)) begin
            n_f_res.status = ST_DAY;
        end else begin
            n_f_res.status = ST_OK;   // check digit resolved next stage
        end

        n_f_sum = '0;
        for (int k = 0; k < ID_DIGITS - 1; k++) begin
            n_f_sum = n_f_sum + SUM_W'(WEIGHTS[k]) * SUM_W'(dig[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_vld <= 1'b0;
        end else if (w_en[DAB_STAGES+1]) begin
            r_f_vld <= r_vld[DAB_STAGES];
        end
        if (w_en[DAB_STAGES+1]) begin
            r_f_res <= n_f_res;
            r_f_sum <= n_f_sum;
        end
    end

    // ---------------------------------------------------------------
    // Check stage: s mod 11 by reciprocal, k = 11 - r (r = 0 gives 0)
    // ---------------------------------------------------------------
    logic [PROD_W-1:0]  prod;
    logic [5:0]         quot;
    logic [SUM_W-1:0]   rem_full;
    logic [3:0]         rem;
    logic [3:0]         k_calc;
    logic               chk_bad;
    t_pinv_res          n_o_res;

    always_comb begin
        prod     = PROD_W'(r_f_sum) * PROD_W'(RECIP11);
        quot     = 6'(prod >> RECIP_SH);
        rem_full = r_f_sum - SUM_W'(quot) * SUM_W'(MOD_BASE);
        rem      = rem_full[3:0];
        k_calc   = (rem == 4'd0) ? 4'd0 : 4'(MOD_BASE) - rem;
        // k of 10 has no digit; r = 1 is exactly that case
        chk_bad  = (rem == 4'd1) || (k_calc != r_f_res.check_digit);

        n_o_res = r_f_res;
        if (r_f_res.status == ST_OK && chk_bad) begin
            n_o_res.status = ST_CHECK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (w_out_en) begin
            r_o_vld <= r_f_vld;
        end
        if (w_out_en) begin
            r_o_res <= n_o_res;
        end
    end

    assign o_out.valid       = r_o_vld;
    assign o_out.status      = r_o_res.status;
    assign o_out.birth_day   = r_o_res.birth_day;
    assign o_out.birth_month = r_o_res.birth_month;
    assign o_out.birth_year  = r_o_res.birth_year;
    assign o_out.region_code = r_o_res.region_code;
    assign o_out.serial_code = r_o_res.serial_code;
    assign o_out.is_female   = r_o_res.is_female;
    assign o_out.check_digit = r_o_res.check_digit;

endmodule

>>> sim/personal_id_number_validator_tb.sv
module personal_id_number_validator_tb;
    import pinv_pkg::*;

    // Days per month, February always 28; index is month - 1.
    localparam int unsigned DAYS_IN_MONTH [12] = '{31, 28, 31, 30, 31, 30,
                                                   31, 31, 30, 31, 30, 31};
    // Check digit weights for d0..d11.
    localparam int unsigned DIGIT_WEIGHT [12] = '{7, 6, 5, 4, 3, 2,
                                                  7, 6, 5, 4, 3, 2};
    localparam longint unsigned ID_MIN   = 64'd100000000000;   // smallest 12-digit ID
    localparam longint unsigned ID_MAX   = 64'd9999999999999;  // largest 13-digit ID
    localparam longint unsigned ID_SPAN  = 64'd10000000000000; // 10^13
    localparam int              RANDOM_N = 625;
    localparam int              DRAIN_AT [3] = '{30, 250, 500};

    typedef struct {
        logic [ID_W-1:0] id;
        bit              drain_first; // hold this beat until nothing is in flight
    } t_id_beat;

    logic i_clk;
    logic i_rst_n;

    pinv_in_if  in_if ();
    pinv_out_if out_if ();

    personal_id_number_validator u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    t_id_beat  pending_ids [$];   // IDs not yet presented
    t_pinv_res results_due [$];   // decoded results for accepted IDs, oldest first

    int          fail_cnt   = 0;
    int          sent_cnt   = 0;
    int          recv_cnt   = 0;
    int          in_flight  = 0;
    int unsigned gap_left   = 0;
    int unsigned stall_left = 0;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Weighted mod-11 digit for a 12-digit prefix d0..d11. Returns 10 when
    // no check digit can make the ID valid; a remainder of zero gives 0.
    function automatic int unsigned mod11_digit(input longint unsigned prefix);
        longint unsigned rest;
        int unsigned     sum;
        int unsigned     k;
        rest = prefix;
        sum  = 0;
        for (int i = 11; i >= 0; i--) begin
            sum  += DIGIT_WEIGHT[i] * int'(rest % 10);
            rest /= 10;
        end
        k = 11 - (sum % 11);
        if (k == 11) k = 0;
        return k;
    endfunction

    // Full decode of one ID: fields always come from the low 13 digits,
    // status is the first failing check.
    function automatic t_pinv_res jmbg_decode(input logic [ID_W-1:0] id);
        longint unsigned v;
        longint unsigned rest;
        int unsigned     dg [13];
        int unsigned     day, month, ydig, region, serial, k;
        t_pinv_res       r;
        v    = 64'(id);
        rest = v;
        for (int i = 12; i >= 0; i--) begin
            dg[i] = int'(rest % 10);
            rest /= 10;
        end
        day    = dg[0] * 10 + dg[1];
        month  = dg[2] * 10 + dg[3];
        ydig   = dg[4] * 100 + dg[5] * 10 + dg[6];
        region = dg[7] * 10 + dg[8];
        serial = dg[9] * 100 + dg[10] * 10 + dg[11];
        k      = mod11_digit((v % ID_SPAN) / 10);

        if (v < ID_MIN || v > ID_MAX)
            r.status = ST_COUNT;
        else if (!(ydig <= 17 || (ydig >= 927 && ydig <= 999)))
            r.status = ST_YEAR;
        else if (month < 1 || month > 12)
            r.status = ST_MONTH;
        else if (day < 1 || day > DAYS_IN_MONTH[month-1])
            r.status = ST_DAY;
        else if (k == 10 || k != dg[12])
            r.status = ST_CHECK;
        else
            r.status = ST_OK;

        r.birth_day   = DAY_W'(day);
        r.birth_month = MONTH_W'(month);
        r.birth_year  = YEAR_W'(ydig >= 927 ? 1000 + ydig : 2000 + ydig);
        r.region_code = REGION_W'(region);
        r.serial_code = SERIAL_W'(serial);
        r.is_female   = (serial > 499);
        r.check_digit = CHECK_W'(dg[12]);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic longint unsigned id_prefix(input int unsigned day,
                                                  input int unsigned month,
                                                  input int unsigned ydig,
                                                  input int unsigned region,
                                                  input int unsigned serial);
        return (((64'(day) * 100 + month) * 1000 + ydig) * 100 + region) * 1000 + serial;
    endfunction

    // Append the proper check digit; an unsealable prefix gets 0 and so fails.
    function automatic longint unsigned sealed_id(input longint unsigned prefix);
        int unsigned k;
        k = mod11_digit(prefix);
        return prefix * 10 + (k == 10 ? 0 : k);
    endfunction

    // First region code that makes a fixed prefix land on the wanted digit.
    function automatic int unsigned region_for(input int unsigned want);
        for (int rg = 0; rg < 100; rg++)
            if (mod11_digit(id_prefix(12, 3, 985, rg, 123)) == want) return rg;
        return 0;
    endfunction

    function automatic void add_id(input longint unsigned v);
        t_id_beat b;
        b.id          = v[ID_W-1:0];
        b.drain_first = 1'b0;
        pending_ids.push_back(b);
    endfunction

    task automatic compare_field(input string name, input logic [15:0] want,
                                 input logic [15:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_cnt++;
        end
    endtask

    // ------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Driver: presents queued IDs with random idle gaps between beats,
    // except in every window of 40 beats out of 150 where it runs flat out.
    // A beat marked drain_first waits until every result has come back.
    // in_flight is tracked from the sampled handshakes on both channels.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : drive
        t_id_beat nxt;
        if (!i_rst_n) begin
            in_if.valid     <= 1'b0;
            in_if.id_number <= '0;
            gap_left        <= 0;
            in_flight        = 0;
        end else begin
            in_flight = in_flight + int'(in_if.valid && in_if.ready)
                                  - int'(out_if.valid && out_if.ready);
            if (in_if.valid && !in_if.ready) begin
                // beat still waiting, hold it
            end else if (gap_left != 0) begin
                in_if.valid <= 1'b0;
                gap_left    <= gap_left - 1;
            end else if (pending_ids.size() != 0 &&
                         (!pending_ids[0].drain_first || in_flight == 0)) begin
                nxt = pending_ids.pop_front();
                in_if.valid     <= 1'b1;
                in_if.id_number <= nxt.id;
                gap_left        <= (sent_cnt % 150 >= 110) ? 0 : $urandom_range(0, 3);
                sent_cnt++;
            end else begin
                in_if.valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: stalls the output at random after each result (none in a window of
    // each 150 results), checks each result against the oldest prediction,
    // and records a prediction for every accepted input beat. A result can
    // never leave in the cycle its ID enters, so checking before recording
    // is safe.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : watch
        t_pinv_res   got;
        t_pinv_res   want;
        int unsigned stall;
        if (!i_rst_n) begin
            out_if.ready <= 1'b1;
            stall_left   <= 0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                got.status      = out_if.status;
                got.birth_day   = out_if.birth_day;
                got.birth_month = out_if.birth_month;
                got.birth_year  = out_if.birth_year;
                got.region_code = out_if.region_code;
                got.serial_code = out_if.serial_code;
                got.is_female   = out_if.is_female;
                got.check_digit = out_if.check_digit;
                if (results_due.size() == 0) begin
                    $error("result beat with no ID outstanding (status %0d)", got.status);
                    fail_cnt++;
                end else begin
                    want = results_due.pop_front();
                    compare_field("status",      16'(want.status),      16'(got.status));
                    compare_field("birth_day",   16'(want.birth_day),   16'(got.birth_day));
                    compare_field("birth_month", 16'(want.birth_month), 16'(got.birth_month));
                    compare_field("birth_year",  16'(want.birth_year),  16'(got.birth_year));
                    compare_field("region_code", 16'(want.region_code), 16'(got.region_code));
                    compare_field("serial_code", 16'(want.serial_code), 16'(got.serial_code));
                    compare_field("is_female",   16'(want.is_female),   16'(got.is_female));
                    compare_field("check_digit", 16'(want.check_digit), 16'(got.check_digit));
                end
                recv_cnt++;
                stall = (recv_cnt % 150 < 40) ? 0 : $urandom_range(0, 3);
                if (stall == 0) begin
                    out_if.ready <= 1'b1;
                end else begin
                    out_if.ready <= 1'b0;
                    stall_left   <= stall;
                end
            end else if (stall_left != 0) begin
                stall_left   <= stall_left - 1;
                out_if.ready <= (stall_left == 1);
            end
            if (in_if.valid && in_if.ready)
                results_due.push_back(jmbg_decode(in_if.id_number));
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------
    initial begin
        longint unsigned v;
        longint unsigned pre;
        int unsigned     mon, dy, yr, rg, sr, kind;

        i_rst_n = 1'b0;

        // Directed: digit-count edges, all-ones, zero.
        add_id(0);
        add_id(64'hFFF_FFFF_FFFF);
        add_id(ID_MIN - 1);                          // 11 digits
        add_id(ID_MIN);                              // 12 digits, month 00
        add_id(ID_MAX);                              // 13 nines
        add_id(ID_MAX + 1);                          // 14 digits, top one dropped
        // Well-formed IDs at the year window edges, 12 and 13 digits.
        add_id(sealed_id(id_prefix(1, 1, 999, 71, 0)));
        add_id(sealed_id(id_prefix(31, 12, 927, 99, 999)));
        add_id(sealed_id(id_prefix(28, 2, 0, 10, 499)));   // last male serial
        add_id(sealed_id(id_prefix(15, 6, 17, 50, 500)));  // first female serial
        // Year just outside each window.
        add_id(sealed_id(id_prefix(10, 10, 18, 20, 123)));
        add_id(sealed_id(id_prefix(10, 10, 926, 20, 123)));
        // Month zero and thirteen.
        add_id(sealed_id(id_prefix(10, 0, 990, 30, 456)));
        add_id(sealed_id(id_prefix(10, 13, 990, 30, 456)));
        // Day past month end, February with no leap day, April 30/31, Jan 31.
        add_id(sealed_id(id_prefix(32, 1, 985, 40, 789)));
        add_id(sealed_id(id_prefix(29, 2, 3, 40, 789)));
        add_id(sealed_id(id_prefix(31, 4, 950, 40, 789)));
        add_id(sealed_id(id_prefix(30, 4, 950, 40, 789)));
        add_id(sealed_id(id_prefix(31, 1, 5, 40, 789)));
        // Wrong check digit on an otherwise valid ID.
        v = sealed_id(id_prefix(20, 8, 960, 17, 321));
        add_id(v - v % 10 + (v % 10 + 1) % 10);
        // Sum that no check digit can satisfy; remainder zero giving digit 0.
        add_id(id_prefix(12, 3, 985, region_for(10), 123) * 10);
        add_id(sealed_id(id_prefix(12, 3, 985, region_for(0), 123)));

        // Random: mostly well-formed IDs with random content, then single-field
        // breakage, numbers in the 12..13 digit range, and raw 44-bit noise.
        for (int n = 0; n < RANDOM_N; n++) begin
            mon  = $urandom_range(1, 12);
            dy   = $urandom_range(1, DAYS_IN_MONTH[mon-1]);
            yr   = $urandom_range(0, 1) ? $urandom_range(0, 17) : $urandom_range(927, 999);
            rg   = $urandom_range(0, 99);
            sr   = $urandom_range(0, 999);
            kind = $urandom_range(0, 99);
            if (kind < 60) begin
                v = sealed_id(id_prefix(dy, mon, yr, rg, sr));
            end else if (kind < 75) begin
                case ($urandom_range(0, 3))
                    0: yr  = $urandom_range(18, 926);
                    1: mon = $urandom_range(0, 1) ? 0 : $urandom_range(13, 99);
                    2: dy  = $urandom_range(DAYS_IN_MONTH[mon-1] + 1, 99);
                    default: ;
                endcase
                pre = id_prefix(dy, mon, yr, rg, sr);
                v   = sealed_id(pre);
                if (kind >= 71) // wrong check digit
                    v = v - v % 10 + (v % 10 + $urandom_range(1, 9)) % 10;
            end else if (kind < 85) begin
                v = ID_MIN + {$urandom(), $urandom()} % (ID_MAX - ID_MIN + 1);
            end else begin
                v = {$urandom(), $urandom()};
            end
            add_id(v);
        end

        // Let the pipeline empty completely before a few beats.
        foreach (DRAIN_AT[i]) pending_ids[DRAIN_AT[i]].drain_first = 1'b1;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        do @(negedge i_clk);
        while (pending_ids.size() != 0 || in_if.valid || results_due.size() != 0);
        // Pipeline is 14 deep; wait past it for any stray result beat.
        repeat (40) @(posedge i_clk);

        if (fail_cnt == 0)
            $display("personal_id_number_validator_tb passed");
        else
            $display("personal_id_number_validator_tb failed");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #4000000;
        $display("personal_id_number_validator_tb failed");
        $finish;
    end

endmodule
